// ----- design/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// ght_pkg
// shared types and constants of the generational handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int SIDX_W    = 11;
  localparam int RIDX_W    = 10;

  localparam logic [DATA_W-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    CMD_ALLOC      = 4'd0,
    CMD_FREE       = 4'd1,
    CMD_RESOLVE    = 4'd2,
    CMD_HANDLE_OF  = 4'd3,
    CMD_OBJECT_OF  = 4'd4,
    CMD_ADD_STRONG = 4'd5,
    CMD_REL_STRONG = 4'd6,
    CMD_ADD_WEAK   = 4'd7,
    CMD_REL_WEAK   = 4'd8,
    CMD_STRONG_CNT = 4'd9,
    CMD_IS_REF     = 4'd10,
    CMD_ALIVE      = 4'd11
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_FULL  = 3'd1,
    STS_RANGE = 3'd2,
    STS_GEN   = 3'd3,
    STS_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // one slot entry as it sits in the slot memory
  typedef struct packed {
    logic [DATA_W-1:0] obj;
    logic [DATA_W-1:0] gen;
    logic [DATA_W-1:0] strong_cnt;
    logic [DATA_W-1:0] weak_cnt;
  } slot_t;

  // free stack and high-water mark control
  typedef struct packed {
    logic push;
    logic pop;
    logic bump;
  } stk_ctrl_t;

  typedef struct packed {
    status_t           status;
    logic [RIDX_W-1:0] r_idx;
    logic [DATA_W-1:0] r_gen;
    logic [DATA_W-1:0] r_obj;
    logic [DATA_W-1:0] cnt;
    logic              flag;
  } res_t;

endpackage

// ----- design/ght_slot_ram.sv -----
// ----------------------------------------------------------------------------
// ght_slot_ram
// slot memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ght_slot_ram #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  ght_pkg::slot_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output ght_pkg::slot_t rdata
);

  ght_pkg::slot_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ght_free_stack.sv -----
// ----------------------------------------------------------------------------
// ght_free_stack
// stack of freed slot indexes with a cached top, plus the high-water mark
// ----------------------------------------------------------------------------
module ght_free_stack #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ght_pkg::stk_ctrl_t  ctrl,
  input  logic [AW-1:0]       push_idx,
  output logic [AW-1:0]       top_idx,
  output logic [AW:0]         depth,
  output logic [AW:0]         used
);

  logic [AW-1:0] mem [SLOTS];
  logic [AW-1:0] rd_q;
  logic [AW-1:0] top_r;
  logic          pend_r;
  logic [AW:0]   depth_r;
  logic [AW:0]   used_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // after a pop the new top is fetched from memory and shows in the following cycle
  assign rd_en   = ctrl.pop && (depth_r >= (AW+1)'(2));
  assign rd_addr = AW'(depth_r - (AW+1)'(2));
  assign top_idx = pend_r ? rd_q : top_r;
  assign depth   = depth_r;
  assign used    = used_r;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[AW'(depth_r)] <= push_idx;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      used_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (ctrl.push) begin
        depth_r <= depth_r + (AW+1)'(1);
      end else if (ctrl.pop) begin
        depth_r <= depth_r - (AW+1)'(1);
      end
      if (ctrl.bump) begin
        used_r <= used_r + (AW+1)'(1);
      end
      if (rd_en) begin
        pend_r <= 1'b1;
      end else if (ctrl.push || pend_r) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      top_r <= push_idx;
    end else if (pend_r && !rd_en) begin
      top_r <= rd_q;
    end
  end

endmodule

// ----- design/ght_cmd_exec.sv -----
// ----------------------------------------------------------------------------
// ght_cmd_exec
// command decode: result, slot write-back and stack control from read data
// ----------------------------------------------------------------------------
module ght_cmd_exec #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF,
  parameter int AW    = $clog2(SLOTS)
) (
  input  logic [3:0]                 cmd,
  input  logic                       in_range,
  input  logic [AW-1:0]              addr,
  input  logic [ght_pkg::DATA_W-1:0] hgen,
  input  logic [ght_pkg::DATA_W-1:0] obj_ref,
  input  ght_pkg::slot_t             rd,
  input  logic [AW:0]                depth,
  input  logic [AW:0]                used,
  output ght_pkg::res_t              res,
  output logic                       slot_we,
  output ght_pkg::slot_t             slot_wdata,
  output ght_pkg::stk_ctrl_t         stk
);

  logic [ght_pkg::DATA_W-1:0] gen_inc;
  logic [ght_pkg::DATA_W-1:0] strong_inc;
  logic [ght_pkg::DATA_W-1:0] strong_dec;
  logic [ght_pkg::DATA_W-1:0] weak_inc;
  logic [ght_pkg::DATA_W-1:0] weak_dec;
  logic                       live;
  logic                       slot_cmd;

  assign gen_inc    = rd.gen + ght_pkg::DATA_W'(1);
  assign strong_inc = (rd.strong_cnt == ght_pkg::CNT_MAX) ? rd.strong_cnt
                      : rd.strong_cnt + ght_pkg::DATA_W'(1);
  assign strong_dec = (rd.strong_cnt == '0) ? rd.strong_cnt
                      : rd.strong_cnt - ght_pkg::DATA_W'(1);
  assign weak_inc   = (rd.weak_cnt == ght_pkg::CNT_MAX) ? rd.weak_cnt
                      : rd.weak_cnt + ght_pkg::DATA_W'(1);
  assign weak_dec   = (rd.weak_cnt == '0) ? rd.weak_cnt
                      : rd.weak_cnt - ght_pkg::DATA_W'(1);
  assign live       = (rd.obj != '0);
  assign slot_cmd   = (cmd >= ght_pkg::CMD_FREE) && (cmd <= ght_pkg::CMD_IS_REF);

  always_comb begin
    res        = '0;
    res.status = ght_pkg::STS_OK;
    slot_we    = 1'b0;
    slot_wdata = rd;
    stk        = '0;
    if (cmd == ght_pkg::CMD_ALLOC) begin
      if (obj_ref == '0) begin
        res.status = ght_pkg::STS_EMPTY;
      end else if (depth != '0) begin
        stk.pop        = 1'b1;
        slot_we        = 1'b1;
        slot_wdata.gen = gen_inc;
        slot_wdata.obj = obj_ref;
        res.r_idx      = ght_pkg::RIDX_W'(addr);
        res.r_gen      = gen_inc;
      end else if (used < (AW+1)'(SLOTS)) begin
        stk.bump       = 1'b1;
        slot_we        = 1'b1;
        slot_wdata.gen = ght_pkg::DATA_W'(1);
        slot_wdata.obj = obj_ref;
        res.r_idx      = ght_pkg::RIDX_W'(addr);
        res.r_gen      = ght_pkg::DATA_W'(1);
      end else begin
        res.status = ght_pkg::STS_FULL;
      end
    end else if (cmd == ght_pkg::CMD_ALIVE) begin
      res.cnt = ght_pkg::DATA_W'(used - depth);
    end else if (slot_cmd && !in_range) begin
      res.status = ght_pkg::STS_RANGE;
    end else if (slot_cmd) begin
      case (cmd)
        ght_pkg::CMD_FREE: begin
          if (!live) begin
            res.status = ght_pkg::STS_EMPTY;
          end else begin
            slot_we        = 1'b1;
            slot_wdata.obj = '0;
            slot_wdata.gen = gen_inc;
            stk.push       = (depth < (AW+1)'(SLOTS));
          end
        end
        ght_pkg::CMD_RESOLVE: begin
          if (hgen == '0 || hgen != rd.gen) begin
            res.status = ght_pkg::STS_GEN;
          end else if (!live) begin
            res.status = ght_pkg::STS_EMPTY;
          end else begin
            res.r_obj = rd.obj;
          end
        end
        ght_pkg::CMD_HANDLE_OF: begin
          if (!live) begin
            res.status = ght_pkg::STS_EMPTY;
          end else begin
            res.r_idx = ght_pkg::RIDX_W'(addr);
            res.r_gen = rd.gen;
          end
        end
        ght_pkg::CMD_OBJECT_OF: begin
          if (!live) begin
            res.status = ght_pkg::STS_EMPTY;
          end else begin
            res.r_obj = rd.obj;
          end
        end
        ght_pkg::CMD_ADD_STRONG: begin
          slot_we               = 1'b1;
          slot_wdata.strong_cnt = strong_inc;
          res.cnt               = strong_inc;
        end
        ght_pkg::CMD_REL_STRONG: begin
          slot_we               = 1'b1;
          slot_wdata.strong_cnt = strong_dec;
          res.cnt               = strong_dec;
          res.flag              = (strong_dec == '0) && live;
        end
        ght_pkg::CMD_ADD_WEAK: begin
          slot_we             = 1'b1;
          slot_wdata.weak_cnt = weak_inc;
        end
        ght_pkg::CMD_REL_WEAK: begin
          slot_we             = 1'b1;
          slot_wdata.weak_cnt = weak_dec;
        end
        ght_pkg::CMD_STRONG_CNT: begin
          res.cnt = rd.strong_cnt;
        end
        ght_pkg::CMD_IS_REF: begin
          res.flag = (rd.strong_cnt != '0) || (rd.weak_cnt != '0);
        end
        default: begin
          res.status = ght_pkg::STS_OK;
        end
      endcase
    end
  end

endmodule

// ----- design/generational_handle_table_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// slot table handing out index/generation handles, with reference counts
// ----------------------------------------------------------------------------
// In the accept cycle of an item the slot memory is read at the addressed
// slot (for alloc, at the top of the free stack or at the high-water mark);
// in the execute state the command is decoded against the read data, and
// once the result register can take the result, the slot is written back
// and the result is registered. The single read-modify-write through the
// registered slot memory sets this order; as an item is only read once the
// previous write has landed, no two accesses to the same entry overlap. The
// result register frees the input side, so a new item is taken while a
// result still waits; if the result register is occupied and stalled when
// an item finishes, the write-back waits for it. After reset a clearing
// pass zeroes the whole slot memory, and no item is accepted until it ends.
// Alloc pops the most recently freed index, whose successor is fetched from
// the stack memory while the next item is accepted.
// ----------------------------------------------------------------------------
module generational_handle_table_unit #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_command,
  input  logic [ght_pkg::SIDX_W-1:0]  in_slot_index,
  input  logic [ght_pkg::DATA_W-1:0]  in_handle_generation,
  input  logic [ght_pkg::DATA_W-1:0]  in_object_ref,
  // result item
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic [ght_pkg::RIDX_W-1:0]  out_result_index,
  output logic [ght_pkg::DATA_W-1:0]  out_result_generation,
  output logic [ght_pkg::DATA_W-1:0]  out_result_object,
  output logic [ght_pkg::DATA_W-1:0]  out_count_value,
  output logic                        out_flag
);

  localparam int AW = $clog2(SLOTS);

  ght_pkg::state_t state_r, state_nxt;

  // clearing pass counter
  logic [AW-1:0] clr_r, clr_nxt;

  // latched item
  logic [3:0]                 cmd_r;
  logic [AW-1:0]              addr_r;
  logic                       in_range_r;
  logic [ght_pkg::DATA_W-1:0] hgen_r;
  logic [ght_pkg::DATA_W-1:0] obj_r;

  // result register
  logic          out_valid_r;
  ght_pkg::res_t res_r;

  logic          accept;
  logic          commit;
  logic [31:0]   idx_ext;
  logic          in_range;
  logic [AW-1:0] rd_addr;

  // slot memory ports
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  ght_pkg::slot_t ram_wdata;
  ght_pkg::slot_t ram_rdata;

  // free stack
  ght_pkg::stk_ctrl_t stk_ctrl;
  ght_pkg::stk_ctrl_t stk_go;
  logic [AW-1:0]      stk_top;
  logic [AW:0]        stk_depth;
  logic [AW:0]        stk_used;

  // command decode
  ght_pkg::res_t  exec_res;
  logic           exec_we;
  ght_pkg::slot_t exec_wdata;

  assign idx_ext  = 32'(in_slot_index);
  assign in_range = (idx_ext < 32'(SLOTS));

  // alloc reads where it will write: freed slot first, else the next fresh one
  always_comb begin
    if (in_command == ght_pkg::CMD_ALLOC) begin
      rd_addr = (stk_depth != '0) ? stk_top : AW'(stk_used);
    end else begin
      rd_addr = idx_ext[AW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    accept    = 1'b0;
    commit    = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ght_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(SLOTS - 1)) begin
          state_nxt = ght_pkg::ST_IDLE;
        end
      end
      ght_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        if (in_valid) begin
          state_nxt = ght_pkg::ST_EXEC;
        end
      end
      ght_pkg::ST_EXEC: begin
        // write back only when the result register can take the result
        commit = !out_valid_r || !out_stall;
        if (commit) begin
          state_nxt = ght_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ght_pkg::ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ght_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_command;
      addr_r     <= rd_addr;
      in_range_r <= in_range;
      hgen_r     <= in_handle_generation;
      obj_r      <= in_object_ref;
    end
  end

  // write port: clearing pass, else write-back of the finishing item
  always_comb begin
    if (state_r == ght_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = commit && exec_we;
      ram_waddr = addr_r;
      ram_wdata = exec_wdata;
    end
  end

  assign stk_go = commit ? stk_ctrl : '0;

  ght_slot_ram #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  ght_free_stack #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_free_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (stk_go),
    .push_idx (addr_r),
    .top_idx  (stk_top),
    .depth    (stk_depth),
    .used     (stk_used)
  );

  ght_cmd_exec #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_cmd_exec (
    .cmd        (cmd_r),
    .in_range   (in_range_r),
    .addr       (addr_r),
    .hgen       (hgen_r),
    .obj_ref    (obj_r),
    .rd         (ram_rdata),
    .depth      (stk_depth),
    .used       (stk_used),
    .res        (exec_res),
    .slot_we    (exec_we),
    .slot_wdata (exec_wdata),
    .stk        (stk_ctrl)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= exec_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = res_r.status;
  assign out_result_index      = res_r.r_idx;
  assign out_result_generation = res_r.r_gen;
  assign out_result_object     = res_r.r_obj;
  assign out_count_value       = res_r.cnt;
  assign out_flag              = res_r.flag;

endmodule
